FILE: src/ple_pkg.sv
// shared types, codes and constants for the positional list engine
package ple_pkg;

   localparam int DepthDefault = 32;
   localparam int OpW          = 3;
   localparam int PosW         = 6;
   localparam int ValW         = 32;
   localparam int StatW        = 2;
   localparam int CountOutW    = 6;
   localparam int CtlW         = 7;

   localparam logic [OpW-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OpW-1:0] OP_INS_END   = 3'd1;
   localparam logic [OpW-1:0] OP_INS_AT    = 3'd2;
   localparam logic [OpW-1:0] OP_DEL_FRONT = 3'd3;
   localparam logic [OpW-1:0] OP_DEL_END   = 3'd4;
   localparam logic [OpW-1:0] OP_DEL_AT    = 3'd5;
   localparam logic [OpW-1:0] OP_DUMP      = 3'd6;

   localparam logic [StatW-1:0] ST_OK     = 2'd0;
   localparam logic [StatW-1:0] ST_BADPOS = 2'd1;
   localparam logic [StatW-1:0] ST_FULL   = 2'd2;
   localparam logic [StatW-1:0] ST_EMPTY  = 2'd3;

   localparam logic [1:0] MODE_HOLD = 2'd0;
   localparam logic [1:0] MODE_INS  = 2'd1;
   localparam logic [1:0] MODE_DEL  = 2'd2;
   localparam logic [1:0] MODE_ROT  = 2'd3;

   typedef struct packed {
      logic [OpW-1:0]         operation;
      logic [PosW-1:0]        position;
      logic signed [ValW-1:0] value;
   } req_type;

   typedef struct packed {
      logic [StatW-1:0]         status;
      logic signed [ValW-1:0]   item_value;
      logic [CountOutW-1:0]     count_after;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]      mode;
      logic [CtlW-1:0] pos;
      logic [CtlW-1:0] len;
   } cell_ctl_type;

endpackage

FILE: src/ple_cell.sv
// one list cell: holds one element and on a shift takes a neighbor's value, the new value or the head value
module ple_cell import ple_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  cell_ctl_type           ctl,
   input  logic signed [ValW-1:0] new_value,
   input  logic signed [ValW-1:0] left_value,
   input  logic signed [ValW-1:0] right_value,
   input  logic signed [ValW-1:0] head_value,
   output logic signed [ValW-1:0] value
);

   localparam logic [CtlW-1:0] Index     = CtlW'(IDX);
   localparam logic [CtlW-1:0] IndexNext = CtlW'(IDX + 1);

   logic signed [ValW-1:0] value_ff;
   logic signed [ValW-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl.mode)
         MODE_INS: begin
            if (Index > ctl.pos) begin
               value_in = left_value;
            end else if (Index == ctl.pos) begin
               value_in = new_value;
            end
         end
         MODE_DEL: begin
            if (Index >= ctl.pos) begin
               value_in = right_value;
            end
         end
         MODE_ROT: begin
            if (IndexNext < ctl.len) begin
               value_in = right_value;
            end else if (IndexNext == ctl.len) begin
               value_in = head_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: src/positional_list_engine.sv
// top level of the positional list engine: control, status and the cell chain
//
// Keeps an ordered list of up to DEPTH signed 32-bit elements, element 0 first,
// in a row of cells that shift toward their neighbors.
// Request channel (req_valid/req_ready/req_payload): one transaction carries an
// operation, a position and a value. Result channel (rsp_valid/rsp_ready/
// rsp_payload): status, element value, element count after the request and a
// last flag on the final result of each request.
// For inserts and deletes the cells shift (when the status is OK) and the single
// status result is registered at the edge that accepts the request, so the result is
// valid in the next cycle.
// A dump streams one result per cycle while the receiver takes them, element 0
// first, by rotating the cells toward the head; its first result is registered
// from the dump state, entered when the request is accepted. req_ready stays low
// until the last element is sent (one result for an empty list). Operation code 7 is dropped.
// The cell chain makes one shift per cycle while the result slot is free.
// A stalled receiver holds the result register; req_ready and the dump stream
// wait until it is taken.
// Reset empties the list and drops any pending result; cell contents are not
// cleared, only elements below the count are ever read.
module positional_list_engine import ple_pkg::*; #(
   parameter int DEPTH = DepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int CntW = $clog2(DEPTH + 1);
   localparam int CmpW = (CntW > PosW) ? CntW : PosW;
   localparam logic [CntW-1:0] DepthCount = CntW'(DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic                   state_ff, state_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic [CntW-1:0]        dump_idx_ff, dump_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   cell_ctl_type           ctl;
   logic signed [ValW-1:0] cell_value [DEPTH];

   logic                   slot_free;
   logic                   req_fire;
   logic [CmpW-1:0]        count_cmp;
   logic [CmpW-1:0]        pos_cmp;
   logic [CmpW-1:0]        op_pos;
   logic [StatW-1:0]       status;
   logic                   is_ins;
   logic                   is_del;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign count_cmp = CmpW'(count_ff);
   assign pos_cmp   = CmpW'(req_payload.position);

   always_comb begin
      is_ins = 1'b0;
      is_del = 1'b0;
      op_pos = '0;
      case (req_payload.operation)
         OP_INS_FRONT: begin
            is_ins = 1'b1;
         end
         OP_INS_END: begin
            is_ins = 1'b1;
            op_pos = count_cmp;
         end
         OP_INS_AT: begin
            is_ins = 1'b1;
            op_pos = pos_cmp;
         end
         OP_DEL_FRONT: begin
            is_del = 1'b1;
         end
         OP_DEL_END: begin
            is_del = 1'b1;
            op_pos = count_cmp - CmpW'(1);
         end
         OP_DEL_AT: begin
            is_del = 1'b1;
            op_pos = pos_cmp;
         end
         default: begin
            op_pos = '0;
         end
      endcase

      status = ST_OK;
      if (is_ins) begin
         if (op_pos > count_cmp) begin
            status = ST_BADPOS;
         end else if (count_ff >= DepthCount) begin
            status = ST_FULL;
         end
      end else if (is_del) begin
         if (count_ff == '0) begin
            status = ST_EMPTY;
         end else if (op_pos >= count_cmp) begin
            status = ST_BADPOS;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dump_idx_in  = dump_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ctl.mode     = MODE_HOLD;
      ctl.pos      = CtlW'(op_pos);
      ctl.len      = CtlW'(count_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (is_ins || is_del) begin
                  if (status == ST_OK) begin
                     ctl.mode = is_ins ? MODE_INS : MODE_DEL;
                     count_in = is_ins ? count_ff + CntW'(1) : count_ff - CntW'(1);
                  end
                  rsp_valid_in        = 1'b1;
                  rsp_in.status       = status;
                  rsp_in.item_value   = '0;
                  rsp_in.count_after  = CountOutW'(count_in);
                  rsp_in.last         = 1'b1;
               end else if (req_payload.operation == OP_DUMP) begin
                  if (count_ff == '0) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.status      = ST_EMPTY;
                     rsp_in.item_value  = '0;
                     rsp_in.count_after = CountOutW'(count_ff);
                     rsp_in.last        = 1'b1;
                  end else begin
                     state_in    = S_DUMP;
                     dump_idx_in = '0;
                  end
               end
            end
         end
         S_DUMP: begin
            if (slot_free) begin
               ctl.mode           = MODE_ROT;
               rsp_valid_in       = 1'b1;
               rsp_in.status      = ST_OK;
               rsp_in.item_value  = cell_value[0];
               rsp_in.count_after = CountOutW'(count_ff);
               rsp_in.last        = (dump_idx_ff + CntW'(1)) == count_ff;
               dump_idx_in        = dump_idx_ff + CntW'(1);
               if (rsp_in.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ple_cell #(
         .IDX (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_value   (req_payload.value),
         .left_value  (cell_value[(i == 0) ? 0 : i - 1]),
         .right_value (cell_value[(i == DEPTH - 1) ? i : i + 1]),
         .head_value  (cell_value[0]),
         .value       (cell_value[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCount)
      else $error("element count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + CntW'(1)) ||
                        (count_ff == $past(count_ff) - CntW'(1)))
      else $error("element count moved by more than one");

   a_dump_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |=> count_ff == $past(count_ff))
      else $error("element count changed during dump");

   a_dump_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |-> dump_idx_ff < count_ff)
      else $error("dump index past end of list");

endmodule

FILE: tb/list_checker.sv
// checker for the positional list engine: predicts every result and compares it
module list_checker
   import ple_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      error_count,
   output int      pending_count,
   output int      held_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ListDepth = DepthDefault;
   localparam int IdxW      = $clog2(ListDepth);

   logic signed [ValW-1:0] shadow_cells [ListDepth];
   logic [PosW:0]          shadow_len = '0;
   rsp_type                expected_results [$];
   int                     failures = 0;

   assign error_count = failures;

   function automatic rsp_type make_result(logic [StatW-1:0] st, logic signed [ValW-1:0] v,
                                           logic lst);
      rsp_type r;
      r.status      = st;
      r.item_value  = v;
      r.count_after = shadow_len[CountOutW-1:0];
      r.last        = lst;
      return r;
   endfunction

   function automatic logic [StatW-1:0] insert_at(logic [PosW:0] slot,
                                                 logic signed [ValW-1:0] v);
      if (slot > shadow_len) return ST_BADPOS;
      if (shadow_len >= ListDepth) return ST_FULL;
      for (int i = int'(shadow_len); i > int'(slot); i--) shadow_cells[i] = shadow_cells[i-1];
      shadow_cells[slot[IdxW-1:0]] = v;
      shadow_len++;
      return ST_OK;
   endfunction

   function automatic logic [StatW-1:0] delete_at(logic [PosW:0] slot);
      if (shadow_len == 0) return ST_EMPTY;
      if (slot >= shadow_len) return ST_BADPOS;
      for (int i = int'(slot); i + 1 < int'(shadow_len); i++) shadow_cells[i] = shadow_cells[i+1];
      shadow_len--;
      return ST_OK;
   endfunction

   function automatic void predict_request(req_type r);
      logic [StatW-1:0] st;
      case (r.operation)
         OP_INS_FRONT: st = insert_at('0, r.value);
         OP_INS_END:   st = insert_at(shadow_len, r.value);
         OP_INS_AT:    st = insert_at({1'b0, r.position}, r.value);
         OP_DEL_FRONT: st = delete_at('0);
         OP_DEL_END:   st = delete_at(shadow_len - 1'b1);
         OP_DEL_AT:    st = delete_at({1'b0, r.position});
         OP_DUMP: begin
            if (shadow_len == 0) begin
               expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
            end else begin
               for (int i = 0; i < int'(shadow_len); i++)
                  expected_results.push_back(make_result(ST_OK, shadow_cells[i],
                                                         i == int'(shadow_len) - 1));
            end
            return;
         end
         default: return;
      endcase
      expected_results.push_back(make_result(st, '0, 1'b1));
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_len = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: unexpected result status %0d value %0d count %0d last %0b",
                           $time, rsp_payload.status, rsp_payload.item_value,
                           rsp_payload.count_after, rsp_payload.last);
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.status !== want.status
                   || rsp_payload.item_value !== want.item_value
                   || rsp_payload.count_after !== want.count_after
                   || rsp_payload.last !== want.last) begin
                  failures++;
                  if (failures <= 10)
                     $display({"%0t: mismatch status %0d/%0d value %0d/%0d count %0d/%0d ",
                               "last %0b/%0b (expected/actual)"}, $time,
                              want.status, rsp_payload.status,
                              want.item_value, rsp_payload.item_value,
                              want.count_after, rsp_payload.count_after,
                              want.last, rsp_payload.last);
               end
            end
         end
         if (req_valid && req_ready) predict_request(req_payload);
      end
      pending_count <= expected_results.size();
      held_count    <= int'(shadow_len);
   end

endmodule

FILE: tb/testbench.sv
// testbench top for the positional list engine: clock, reset, stimulus and verdict
module testbench import ple_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OpW-1:0] OP_UNUSED  = 3'd7;
   localparam int             CycleLimit = 400_000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;
   int      error_count;
   int      pending_count;
   int      held_count;
   bit      calm_phase  = 1'b0;
   int      sent_count  = 0;
   int      cycle_count = 0;

   positional_list_engine uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   list_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .error_count   (error_count),
      .pending_count (pending_count),
      .held_count    (held_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL positional_list_engine");
      $finish;
   end

   // receiver: random stalls, one long hold-off while the sender keeps going
   initial begin
      bit long_hold_done;
      long_hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!calm_phase && !long_hold_done && sent_count >= 30) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (150) @(posedge clock);
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   task automatic offer(logic [OpW-1:0] op, logic [PosW-1:0] pos, logic signed [ValW-1:0] val);
      req_valid   <= 1'b1;
      req_payload <= '{operation: op, position: pos, value: val};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op != OP_UNUSED) sent_count++;
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic random_item(int ins_pct, int del_pct);
      int                     pick;
      logic [PosW-1:0]        slot;
      logic signed [ValW-1:0] data;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) slot = PosW'($urandom_range(0, 63));
      else slot = PosW'($urandom_range(0, held_count + 1));
      case ($urandom_range(0, 9))
         0: data = 32'h8000_0000;
         1: data = 32'h7FFF_FFFF;
         default: data = $urandom();
      endcase
      if (pick < ins_pct) begin
         case ($urandom_range(0, 2))
            0: offer(OP_INS_FRONT, slot, data);
            1: offer(OP_INS_END, slot, data);
            default: offer(OP_INS_AT, slot, data);
         endcase
      end else if (pick < ins_pct + del_pct) begin
         case ($urandom_range(0, 2))
            0: offer(OP_DEL_FRONT, slot, data);
            1: offer(OP_DEL_END, slot, data);
            default: offer(OP_DEL_AT, slot, data);
         endcase
      end else if (pick < 95) begin
         offer(OP_DUMP, slot, data);
      end else begin
         offer(OP_UNUSED, slot, data);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer(OP_DUMP, 6'd0, 32'sd0);
      offer(OP_DEL_FRONT, 6'd0, 32'sd0);
      offer(OP_DEL_END, 6'd0, 32'sd0);
      offer(OP_DEL_AT, 6'd63, 32'sd0);
      offer(OP_INS_AT, 6'd1, 32'sd5);
      offer(OP_INS_AT, 6'd0, 32'h8000_0000);
      offer(OP_INS_FRONT, 6'd63, 32'h7FFF_FFFF);
      offer(OP_INS_END, 6'd0, -32'sd1);
      offer(OP_INS_AT, 6'd3, 32'h0000_0000);
      offer(OP_INS_AT, 6'd2, 32'h5555_5555);
      offer(OP_INS_AT, 6'd1, 32'hAAAA_AAAA);
      offer(OP_UNUSED, 6'd0, 32'h1234_5678);
      offer(OP_DUMP, 6'd0, 32'sd0);
      offer(OP_DEL_AT, 6'd5, 32'sd0);
      offer(OP_DEL_AT, 6'd63, 32'sd0);
      offer(OP_DEL_AT, 6'd2, 32'sd0);
      offer(OP_DEL_END, 6'd0, 32'sd0);
      offer(OP_DEL_FRONT, 6'd0, 32'sd0);
      offer(OP_INS_AT, 6'd63, 32'sd1);
      offer(OP_DUMP, 6'd0, 32'sd0);

      // fill to the top, then push against a full list
      while (held_count < DepthDefault) random_item(100, 0);
      repeat (4) random_item(100, 0);
      offer(OP_DUMP, 6'd0, 32'sd0);

      repeat (40) random_item(40, 40);

      // drain past empty
      while (held_count > 0) random_item(0, 100);
      repeat (3) random_item(0, 100);

      repeat (15) random_item(50, 35);

      calm_phase = 1'b1;
      repeat (25) random_item(45, 40);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS positional_list_engine");
      end else begin
         $display("FAIL positional_list_engine");
      end
      $finish;
   end

endmodule
